@@ design/qdh_pkg.sv @@
// ----------------------------------------------------------------------------
// qdh_pkg: shared types and constants for the quantile density histogram
// widths of the stream fields, register indexes, sequencer and unit states
// ----------------------------------------------------------------------------
package qdh_pkg;

	// largest supported interval count
	localparam int unsigned MAX_INTERVALS = 65535;

	localparam int IDX_W      = 16;  // item index, interval count, quantile steps
	localparam int X_W        = 32;  // signed Q16.16 x values
	localparam int H_W        = 32;  // unsigned Q16.16 heights
	localparam int SC_W       = 24;  // sample count
	localparam int MBW_W      = 31;  // min bin width
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam int NUM_W     = SC_W + IDX_W;  // sample_count * k
	localparam int DEN_W     = X_W + IDX_W;   // width * n
	localparam int DIV_STEPS = H_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_BIN_WIDTH  = 2'd2;

	// height unit states
	typedef enum logic [2:0] {
		H_IDLE,
		H_NUM,
		H_DEN,
		H_CMP,
		H_DIV,
		H_DONE
	} hu_state_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_CALC,
		S_EMIT
	} seq_state_t;

	// emit steps, one outline point each but E_DONE
	typedef enum logic [2:0] {
		E_FIRST,
		E_HELD_A,
		E_HELD_B,
		E_BIN_A,
		E_BIN_B,
		E_CLOSE,
		E_DONE
	} emit_step_t;

	// request to the height unit, held steady until done
	typedef struct packed {
		logic                    start;
		logic [IDX_W-1:0]        k;
		logic [IDX_W-1:0]        n;
		logic signed [X_W:0]     width;
	} hu_req_t;

	typedef struct packed {
		logic             done;
		logic [H_W-1:0]   height;
		logic             sat;
	} hu_rsp_t;

endpackage

@@ design/qdh_height.sv @@
// ----------------------------------------------------------------------------
// qdh_height: bin height unit
// one shared multiplier forms numerator and denominator in turn, then a
// restoring divider yields one quotient bit per cycle, with saturation
// ----------------------------------------------------------------------------
module qdh_height (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [qdh_pkg::SC_W-1:0]   sample_count,
	input  qdh_pkg::hu_req_t           req,
	output qdh_pkg::hu_rsp_t           rsp
);

	qdh_pkg::hu_state_t state_q, state_d;

	logic [qdh_pkg::NUM_W-1:0]  num_q;
	logic [qdh_pkg::DEN_W-1:0]  den_q;
	logic [qdh_pkg::DEN_W-1:0]  rem_q;
	logic [qdh_pkg::H_W-1:0]    quot_q;
	logic                       sat_q;
	logic [qdh_pkg::STEP_W-1:0] step_q;

	logic [qdh_pkg::X_W-1:0]    mul_a;
	logic [qdh_pkg::IDX_W-1:0]  mul_b;
	logic [qdh_pkg::DEN_W-1:0]  prod;
	logic                       width_bad;
	logic                       num_ge_den;
	logic [qdh_pkg::DEN_W:0]    shifted;
	logic [qdh_pkg::DEN_W:0]    diff;
	logic                       fits;
	logic [qdh_pkg::DEN_W-1:0]  rem_next;

	assign width_bad  = req.width[qdh_pkg::X_W] || (req.width == '0);
	assign num_ge_den = {{(qdh_pkg::DEN_W-qdh_pkg::NUM_W){1'b0}}, num_q} >= den_q;

	// shared multiplier
	assign prod = qdh_pkg::DEN_W'(mul_a) * qdh_pkg::DEN_W'(mul_b);

	// restoring divide step
	assign shifted  = {rem_q, 1'b0};
	assign diff     = shifted - {1'b0, den_q};
	assign fits     = shifted >= {1'b0, den_q};
	assign rem_next = fits ? diff[qdh_pkg::DEN_W-1:0] : shifted[qdh_pkg::DEN_W-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qdh_pkg::H_IDLE: begin
				if (req.start) begin
					state_d = width_bad ? qdh_pkg::H_DONE : qdh_pkg::H_NUM;
				end
			end
			qdh_pkg::H_NUM: state_d = qdh_pkg::H_DEN;
			qdh_pkg::H_DEN: state_d = qdh_pkg::H_CMP;
			qdh_pkg::H_CMP: state_d = num_ge_den ? qdh_pkg::H_DONE : qdh_pkg::H_DIV;
			qdh_pkg::H_DIV: begin
				if (step_q == qdh_pkg::STEP_W'(qdh_pkg::DIV_STEPS - 1)) begin
					state_d = qdh_pkg::H_DONE;
				end
			end
			qdh_pkg::H_DONE: state_d = qdh_pkg::H_IDLE;
			default: state_d = qdh_pkg::H_IDLE;
		endcase
	end

	// outputs and multiplier operand select
	always_comb begin
		mul_a      = req.width[qdh_pkg::X_W-1:0];
		mul_b      = req.n;
		rsp.done   = 1'b0;
		rsp.height = quot_q;
		rsp.sat    = sat_q;
		unique case (state_q)
			qdh_pkg::H_NUM: begin
				mul_a = qdh_pkg::X_W'(sample_count);
				mul_b = req.k;
			end
			qdh_pkg::H_DONE: rsp.done = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qdh_pkg::H_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			qdh_pkg::H_IDLE: begin
				if (req.start && width_bad) begin
					quot_q <= '1;
					sat_q  <= 1'b1;
				end
			end
			qdh_pkg::H_NUM: num_q <= prod[qdh_pkg::NUM_W-1:0];
			qdh_pkg::H_DEN: den_q <= prod;
			qdh_pkg::H_CMP: begin
				if (num_ge_den) begin
					quot_q <= '1;
					sat_q  <= 1'b1;
				end else begin
					rem_q  <= qdh_pkg::DEN_W'(num_q);
					quot_q <= '0;
					sat_q  <= 1'b0;
					step_q <= '0;
				end
			end
			qdh_pkg::H_DIV: begin
				rem_q  <= rem_next;
				quot_q <= {quot_q[qdh_pkg::H_W-2:0], fits};
				step_q <= step_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

@@ design/quantile_to_density_histogram.sv @@
// ----------------------------------------------------------------------------
// quantile_to_density_histogram: density histogram outline from quantiles
// groups sorted quantiles into bins of a minimum width and emits the outline
// ----------------------------------------------------------------------------
// The block takes n+1 sorted quantile values (signed Q16.16, n from the
// interval_count register) one word at a time and returns the outline of a
// density histogram as (x, height) points. The first word gives (q0, 0); each
// bin of at least min_bin_width is held back one bin and then sent as two
// points with height sample_count*k/(width*n) in unsigned Q16.16; a too narrow
// last group is folded into the held bin; the last word ends with the closing
// (qn, 0) point flagged by last_point. A zero or negative width or an
// overflow saturates the height to all ones and sets height_saturated. One
// word is worked on at a time: a word that closes a bin goes through the bin
// height unit (two passes through its shared multiplier, one compare, 32
// restoring divide steps and a done state), and its points go out one per
// cycle while the output register is free; a zero or negative width skips
// the unit's arithmetic and a height that cannot fit stops right after the
// compare. A first word and a word that only widens the current group do
// not use the unit. in_ready is high only between words. The output register
// lets the last point of a word wait for out_ready while the next word is
// already taken. Registers are to be written between words; the block does
// not enforce this. cfg_ready is always high; an unknown index is ignored.
// ----------------------------------------------------------------------------
module quantile_to_density_histogram (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [qdh_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [qdh_pkg::CFG_DATA_W-1:0]    cfg_data,
	// quantile input
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [qdh_pkg::X_W-1:0]    quantile_value,
	// outline points
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [qdh_pkg::X_W-1:0]    point_x,
	output logic [qdh_pkg::H_W-1:0]           point_height,
	output logic                              height_saturated,
	output logic                              last_point
);

	// configuration registers
	logic [qdh_pkg::IDX_W-1:0]   interval_count_q;
	logic [qdh_pkg::SC_W-1:0]    sample_count_q;
	logic [qdh_pkg::MBW_W-1:0]   min_bin_width_q;

	// sequencer
	qdh_pkg::seq_state_t  state_q, state_d;
	qdh_pkg::emit_step_t  step_q, step_next, step_start;

	// histogram state
	logic [qdh_pkg::X_W-1:0]     x_q;
	logic [qdh_pkg::IDX_W-1:0]   idx_q;
	logic [qdh_pkg::IDX_W-1:0]   gsi_q;
	logic [qdh_pkg::X_W-1:0]     gsx_q;
	logic [qdh_pkg::X_W-1:0]     held_start_q;
	logic [qdh_pkg::X_W-1:0]     held_end_q;
	logic [qdh_pkg::H_W-1:0]     held_h_q;
	logic                        held_sat_q;
	logic                        held_valid_q;

	// bin being sent
	logic [qdh_pkg::X_W-1:0]     bin_start_q;
	logic [qdh_pkg::H_W-1:0]     bin_h_q;
	logic                        bin_sat_q;

	// output register
	logic                        out_valid_q;
	logic [qdh_pkg::X_W-1:0]     out_x_q;
	logic [qdh_pkg::H_W-1:0]     out_h_q;
	logic                        out_sat_q;
	logic                        out_last_q;

	logic [qdh_pkg::IDX_W-1:0]   n_eff;
	logic                        is_first;
	logic                        is_last;
	logic signed [qdh_pkg::X_W:0] span;
	logic signed [qdh_pkg::X_W:0] merge_span;
	logic                        narrow;
	logic                        merge;
	logic [qdh_pkg::X_W:0]       sum;
	logic [qdh_pkg::H_W-1:0]     merged_h;
	logic                        merged_sat;

	logic                        in_fire;
	logic                        load;
	logic [qdh_pkg::X_W-1:0]     pay_x;
	logic [qdh_pkg::H_W-1:0]     pay_h;
	logic                        pay_sat;
	logic                        pay_last;

	qdh_pkg::hu_req_t            hu_req;
	qdh_pkg::hu_rsp_t            hu_rsp;

	// effective n, clamped into 1..MAX_INTERVALS
	always_comb begin
		if (interval_count_q == '0) begin
			n_eff = qdh_pkg::IDX_W'(1);
		end else if (interval_count_q > qdh_pkg::IDX_W'(qdh_pkg::MAX_INTERVALS)) begin
			n_eff = qdh_pkg::IDX_W'(qdh_pkg::MAX_INTERVALS);
		end else begin
			n_eff = interval_count_q;
		end
	end

	// decisions on the current word; all inputs stay put until the word is done
	assign is_first   = (idx_q == '0);
	assign is_last    = (idx_q >= n_eff);
	assign span       = $signed({x_q[qdh_pkg::X_W-1], x_q}) -
	                    $signed({gsx_q[qdh_pkg::X_W-1], gsx_q});
	assign merge_span = $signed({x_q[qdh_pkg::X_W-1], x_q}) -
	                    $signed({held_start_q[qdh_pkg::X_W-1], held_start_q});
	// a negative span counts as narrow
	assign narrow     = span < $signed({2'b00, min_bin_width_q});
	assign merge      = is_last && narrow && held_valid_q;

	// narrow last group folded into the held bin
	assign sum        = {1'b0, held_h_q} + {1'b0, hu_rsp.height};
	assign merged_h   = sum[qdh_pkg::X_W] ? '1 : sum[qdh_pkg::H_W-1:0];
	assign merged_sat = sum[qdh_pkg::X_W] | held_sat_q | hu_rsp.sat;

	// height unit request
	assign hu_req.start = (state_q == qdh_pkg::S_EVAL) && !is_first && !(narrow && !is_last);
	assign hu_req.k     = idx_q - gsi_q;
	assign hu_req.n     = n_eff;
	assign hu_req.width = merge ? merge_span : span;

	qdh_height u_height (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_count (sample_count_q),
		.req          (hu_req),
		.rsp          (hu_rsp)
	);

	// point order: held bin, then (last word) the final bin and the closing point
	assign step_start = (held_valid_q && !merge) ? qdh_pkg::E_HELD_A :
	                    (is_last ? qdh_pkg::E_BIN_A : qdh_pkg::E_DONE);

	always_comb begin
		unique case (step_q)
			qdh_pkg::E_FIRST:  step_next = qdh_pkg::E_DONE;
			qdh_pkg::E_HELD_A: step_next = qdh_pkg::E_HELD_B;
			qdh_pkg::E_HELD_B: step_next = is_last ? qdh_pkg::E_BIN_A : qdh_pkg::E_DONE;
			qdh_pkg::E_BIN_A:  step_next = qdh_pkg::E_BIN_B;
			qdh_pkg::E_BIN_B:  step_next = qdh_pkg::E_CLOSE;
			qdh_pkg::E_CLOSE:  step_next = qdh_pkg::E_DONE;
			default:           step_next = qdh_pkg::E_DONE;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			qdh_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = qdh_pkg::S_EVAL;
				end
			end
			qdh_pkg::S_EVAL: begin
				if (is_first) begin
					state_d = qdh_pkg::S_EMIT;
				end else if (narrow && !is_last) begin
					state_d = qdh_pkg::S_IDLE;
				end else begin
					state_d = qdh_pkg::S_CALC;
				end
			end
			qdh_pkg::S_CALC: begin
				if (hu_rsp.done) begin
					state_d = qdh_pkg::S_EMIT;
				end
			end
			qdh_pkg::S_EMIT: begin
				if (step_q == qdh_pkg::E_DONE) begin
					state_d = qdh_pkg::S_IDLE;
				end
			end
			default: state_d = qdh_pkg::S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_ready = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			qdh_pkg::S_IDLE: in_ready = 1'b1;
			qdh_pkg::S_EMIT: load = (step_q != qdh_pkg::E_DONE) && (!out_valid_q || out_ready);
			default: ;
		endcase
	end

	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// point payload for the current step
	always_comb begin
		pay_x    = x_q;
		pay_h    = '0;
		pay_sat  = 1'b0;
		pay_last = 1'b0;
		case (step_q)
			qdh_pkg::E_HELD_A: begin
				pay_x   = held_start_q;
				pay_h   = held_h_q;
				pay_sat = held_sat_q;
			end
			qdh_pkg::E_HELD_B: begin
				pay_x   = held_end_q;
				pay_h   = held_h_q;
				pay_sat = held_sat_q;
			end
			qdh_pkg::E_BIN_A: begin
				pay_x   = bin_start_q;
				pay_h   = bin_h_q;
				pay_sat = bin_sat_q;
			end
			qdh_pkg::E_BIN_B: begin
				pay_h   = bin_h_q;
				pay_sat = bin_sat_q;
			end
			qdh_pkg::E_CLOSE: pay_last = 1'b1;
			default: ;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_count_q <= qdh_pkg::IDX_W'(1);
			sample_count_q   <= qdh_pkg::SC_W'(1);
			min_bin_width_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qdh_pkg::REG_INTERVAL_COUNT: interval_count_q <= cfg_data[qdh_pkg::IDX_W-1:0];
				qdh_pkg::REG_SAMPLE_COUNT:   sample_count_q   <= cfg_data[qdh_pkg::SC_W-1:0];
				qdh_pkg::REG_MIN_BIN_WIDTH:  min_bin_width_q  <= cfg_data[qdh_pkg::MBW_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and histogram state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= qdh_pkg::S_IDLE;
			step_q       <= qdh_pkg::E_DONE;
			idx_q        <= '0;
			gsi_q        <= '0;
			gsx_q        <= '0;
			held_start_q <= '0;
			held_end_q   <= '0;
			held_h_q     <= '0;
			held_sat_q   <= 1'b0;
			held_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				qdh_pkg::S_EVAL: begin
					if (is_first) begin
						step_q <= qdh_pkg::E_FIRST;
					end else if (narrow && !is_last) begin
						// group too narrow yet, keep extending it
						idx_q <= idx_q + 1'b1;
					end
				end
				qdh_pkg::S_CALC: begin
					if (hu_rsp.done) begin
						step_q <= step_start;
					end
				end
				qdh_pkg::S_EMIT: begin
					if (step_q == qdh_pkg::E_DONE) begin
						if (is_first) begin
							gsx_q        <= x_q;
							gsi_q        <= '0;
							held_valid_q <= 1'b0;
							held_sat_q   <= 1'b0;
							idx_q        <= qdh_pkg::IDX_W'(1);
						end else if (is_last) begin
							// stream done, back to a fresh histogram
							idx_q        <= '0;
							gsi_q        <= '0;
							gsx_q        <= '0;
							held_start_q <= '0;
							held_end_q   <= '0;
							held_h_q     <= '0;
							held_sat_q   <= 1'b0;
							held_valid_q <= 1'b0;
						end else begin
							// new bin goes into the hold slot
							held_start_q <= bin_start_q;
							held_end_q   <= x_q;
							held_h_q     <= bin_h_q;
							held_sat_q   <= bin_sat_q;
							held_valid_q <= 1'b1;
							gsx_q        <= x_q;
							gsi_q        <= idx_q;
							idx_q        <= idx_q + 1'b1;
						end
					end else if (load) begin
						step_q <= step_next;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q <= quantile_value;
		end
		if ((state_q == qdh_pkg::S_CALC) && hu_rsp.done) begin
			if (merge) begin
				bin_start_q <= held_start_q;
				bin_h_q     <= merged_h;
				bin_sat_q   <= merged_sat;
			end else begin
				bin_start_q <= gsx_q;
				bin_h_q     <= hu_rsp.height;
				bin_sat_q   <= hu_rsp.sat;
			end
		end
		if (load) begin
			out_x_q    <= pay_x;
			out_h_q    <= pay_h;
			out_sat_q  <= pay_sat;
			out_last_q <= pay_last;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid        = out_valid_q;
	assign point_x          = out_x_q;
	assign point_height     = out_h_q;
	assign height_saturated = out_sat_q;
	assign last_point       = out_last_q;

endmodule
